// ===== sv/rs485_command_frame_receiver_unit_macros.svh =====
// ---------------------------------------------------------------------------
// RS-485 command frame receiver: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the active-low reset is applied.
// ---------------------------------------------------------------------------
`ifndef RS485_COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH
`define RS485_COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rcfr_pkg.sv =====
// ---------------------------------------------------------------------------
// RS-485 command frame receiver package
// Types, field widths and protocol byte codes shared by the receiver files.
// ---------------------------------------------------------------------------
package rcfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int EVENT_W       = 3;
    localparam int TIME_IDX_W    = 4;
    localparam int STAFF_IDX_W   = 8;
    localparam int STORE_INDEX_W = 8;

    // Stream widths: tdata is padded up to whole bytes.
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 5;

    // Protocol byte codes.
    localparam logic [BYTE_W-1:0] CMD_MASK      = 8'h82;
    localparam logic [BYTE_W-1:0] CMD_PATTERN   = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_STATUS    = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_TIME      = 8'h81;
    localparam logic [BYTE_W-1:0] CMD_STAFF     = 8'h84;
    localparam logic [BYTE_W-1:0] CMD_FORWARD   = 8'h85;
    localparam logic [BYTE_W-1:0] BYTE_BCAST    = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_END      = 8'hFE;

    typedef enum logic [3:0] {
        ST_IDLE        = 4'd0,
        ST_REQ_ADDR    = 4'd1,
        ST_REQ_END     = 4'd2,
        ST_TIME_BC     = 4'd3,
        ST_TIME_DATA   = 4'd4,
        ST_STAFF_BC    = 4'd5,
        ST_STAFF_DATA  = 4'd6,
        ST_FWD_STATION = 4'd7,
        ST_FWD_READER  = 4'd8,
        ST_FWD_END     = 4'd9,
        ST_DONE        = 4'd10
    } t_parse_state;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_STATUS  = 3'd1,
        EV_TIME    = 3'd2,
        EV_STAFF   = 3'd3,
        EV_FORWARD = 3'd4
    } t_event;

    typedef enum logic {
        TGT_TIME  = 1'b0,
        TGT_STAFF = 1'b1
    } t_target;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_event                   event_res;
        logic                     store_valid;
        t_target                  store_target;
        logic [STORE_INDEX_W-1:0] store_index;
        logic [BYTE_W-1:0]        store_data;
        logic [BYTE_W-1:0]        reader_number;
    } t_result;

endpackage

// ===== sv/rcfr_parser.sv =====
// ---------------------------------------------------------------------------
// RS-485 command frame parser
// Frame state machine and buffer counters; computes the result of one item
// and advances its state when the item is stepped through.
// ---------------------------------------------------------------------------
module rcfr_parser
    import rcfr_pkg::*;
#(
    parameter int TIME_BYTES  = 8,
    parameter int STAFF_BYTES = 161
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_item             i_item,
    input  logic [BYTE_W-1:0] i_local_address,
    output t_result           o_result
);

    localparam logic [TIME_IDX_W-1:0]  TIME_LIMIT  = TIME_IDX_W'(TIME_BYTES);
    localparam logic [STAFF_IDX_W-1:0] STAFF_LIMIT = STAFF_IDX_W'(STAFF_BYTES);

    t_parse_state           r_state, n_state;
    logic [TIME_IDX_W-1:0]  r_time_idx, n_time_idx;
    logic [STAFF_IDX_W-1:0] r_staff_idx, n_staff_idx;
    logic [BYTE_W-1:0]      r_reader, n_reader;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_time_idx  <= '0;
            r_staff_idx <= '0;
            r_reader    <= '0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_time_idx  <= n_time_idx;
            r_staff_idx <= n_staff_idx;
            r_reader    <= n_reader;
        end
    end

    always_comb begin
        logic [BYTE_W-1:0] b;
        b           = i_item.rx_byte;
        n_state     = r_state;
        n_time_idx  = r_time_idx;
        n_staff_idx = r_staff_idx;
        n_reader    = r_reader;
        o_result    = '0;

        priority if (i_item.command) begin
            n_state = ST_IDLE;
        end else if (r_state == ST_DONE) begin
            n_state = ST_DONE;
        end else if ((b & CMD_MASK) == CMD_PATTERN) begin
            // A command byte restarts parsing; unknown commands change nothing.
            unique case (b)
                CMD_STATUS:  n_state = ST_REQ_ADDR;
                CMD_TIME:    n_state = ST_TIME_BC;
                CMD_STAFF:   n_state = ST_STAFF_BC;
                CMD_FORWARD: n_state = ST_FWD_STATION;
                default:     n_state = r_state;
            endcase
        end else begin
            unique case (r_state)
                ST_REQ_ADDR: begin
                    n_state = (b == i_local_address) ? ST_REQ_END : ST_IDLE;
                end
                ST_REQ_END: begin
                    if (b == BYTE_END) begin
                        o_result.event_res = EV_STATUS;
                        n_state            = ST_DONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_TIME_BC: begin
                    if (b == BYTE_BCAST) begin
                        n_state    = ST_TIME_DATA;
                        n_time_idx = '0;
                    end
                end
                ST_TIME_DATA: begin
                    if (b == BYTE_END || r_time_idx >= TIME_LIMIT) begin
                        o_result.event_res = EV_TIME;
                        n_state            = ST_DONE;
                    end else begin
                        o_result.store_valid  = 1'b1;
                        o_result.store_target = TGT_TIME;
                        o_result.store_index  = STORE_INDEX_W'(r_time_idx);
                        o_result.store_data   = b;
                        n_time_idx            = r_time_idx + 1'b1;
                    end
                end
                ST_STAFF_BC: begin
                    if (b == BYTE_BCAST) begin
                        n_state     = ST_STAFF_DATA;
                        n_staff_idx = '0;
                    end
                end
                ST_STAFF_DATA: begin
                    if (b == BYTE_END || r_staff_idx >= STAFF_LIMIT) begin
                        o_result.event_res = EV_STAFF;
                        n_state            = ST_DONE;
                    end else begin
                        o_result.store_valid  = 1'b1;
                        o_result.store_target = TGT_STAFF;
                        o_result.store_index  = STORE_INDEX_W'(r_staff_idx);
                        o_result.store_data   = b;
                        n_staff_idx           = r_staff_idx + 1'b1;
                    end
                end
                ST_FWD_STATION: begin
                    if (b == i_local_address) begin
                        n_state = ST_FWD_READER;
                    end
                end
                ST_FWD_READER: begin
                    n_reader = b;
                    n_state  = ST_FWD_END;
                end
                ST_FWD_END: begin
                    if (b == BYTE_END) begin
                        o_result.event_res     = EV_FORWARD;
                        o_result.reader_number = r_reader;
                        n_state                = ST_DONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_IDLE, ST_DONE: begin
                    n_state = r_state;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/rs485_command_frame_receiver_unit.sv =====
// ---------------------------------------------------------------------------
// RS-485 command frame receiver
// Parses upstream serial bytes into status, time, staff and forward frames.
// ---------------------------------------------------------------------------
// Each input transaction carries one received byte, or a host release when
// s_axis_tuser is set. Every input transaction yields exactly one output
// transaction, in order: an event code, an optional payload buffer write
// (target, index, data) and the reader number captured by a forward request.
// The block accepts one transaction per clock cycle while the output is not
// stalled. The byte is captured in an input register when it is accepted,
// the frame state machine handles it combinationally, and its result is
// loaded into an output register when the held byte steps through, where it
// is held until taken. A new byte can be accepted in the same cycle as the
// held one moves on. Once a frame completes, further bytes yield empty
// results until a release returns the parser to idle. The station address
// register resets to 1 and should be written only while no transactions are
// in flight; the configuration channel is always ready.
module rs485_command_frame_receiver_unit
    import rcfr_pkg::*;
#(
    parameter int TIME_BYTES  = 8,
    parameter int STAFF_BYTES = 161
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [0] command (1 = host release)
    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] store_index,
                                                   // [15:8] store_data,
                                                   // [23:16] reader_number
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [2:0] event_res,
                                                   // [3] store_valid,
                                                   // [4] store_target
    // Station address register write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [BYTE_W-1:0]      i_cfg_data
);

    logic [BYTE_W-1:0] r_addr;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_step;

    // The station address is written directly; the channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 8'd1;
        end else begin
            if (i_cfg_valid) begin
                r_addr <= i_cfg_data;
            end
        end
    end

    // The held item moves on whenever the output register is empty or is
    // being emptied in this cycle, so a full pipeline still runs at one
    // transaction per cycle.
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.command <= s_axis_tuser[0];
            r_in_item.rx_byte <= s_axis_tdata[BYTE_W-1:0];
        end
    end

    rcfr_parser #(
        .TIME_BYTES  (TIME_BYTES),
        .STAFF_BYTES (STAFF_BYTES)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_item          (r_in_item),
        .i_local_address (r_addr),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.reader_number, r_out.store_data, r_out.store_index};
    assign m_axis_tuser  = {r_out.store_target, r_out.store_valid, r_out.event_res};

endmodule

// ===== sv/rcfr_checker.sv =====
// ---------------------------------------------------------------------------
// RS-485 command frame receiver checker
// Port-level assertions on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "rs485_command_frame_receiver_unit_macros.svh"

module rcfr_checker
    import rcfr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [OUT_TDATA_W-1:0] i_out_data,
    input logic [OUT_TUSER_W-1:0] i_out_user
);

    // A stalled result must not change.
    `RCFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data) && $stable(i_out_user), "result changed while stalled")

    // A buffer write never coincides with a frame event.
    `RCFR_ASSERT_SAME(a_store_no_event, i_clk, i_rst_n, i_out_valid && i_out_user[3], i_out_user[2:0] == EV_NONE, "buffer write carried an event")

    // Without a buffer write the store fields are zero.
    `RCFR_ASSERT_SAME(a_store_fields_zero, i_clk, i_rst_n, i_out_valid && !i_out_user[3], i_out_user[4] == 1'b0 && i_out_data[15:0] == 16'd0, "idle store fields not zero")

    // The reader number is reported only with a forward request.
    `RCFR_ASSERT_SAME(a_reader_only_forward, i_clk, i_rst_n, i_out_valid && i_out_user[2:0] != EV_FORWARD, i_out_data[23:16] == 8'd0, "reader number outside forward request")

endmodule

bind rs485_command_frame_receiver_unit rcfr_checker u_rcfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (m_axis_tvalid),
    .i_out_ready (m_axis_tready),
    .i_out_data  (m_axis_tdata),
    .i_out_user  (m_axis_tuser)
);

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// RS-485 command frame receiver testbench
// Sends serial bytes and host releases into the receiver and checks every
// result transaction against a cycle-free parser model kept in this bench.
// A short scripted sequence comes first, then random frames under four
// station addresses, with random idling on both streams.
// ---------------------------------------------------------------------------
module testbench;
    import rcfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_CAP     = 8;
    localparam int STAFF_CAP    = 161;
    localparam int ITEM_GOAL    = 1950;
    localparam int CALM_TAIL    = 150;
    localparam int SETTLE_CYC   = 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SCRIPT_LEN   = 27;

    localparam t_result RES_EMPTY = '{EV_NONE, 1'b0, TGT_TIME, 8'h00, 8'h00, 8'h00};

    // Clock, reset and block ports. Every input starts at a known value.
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [BYTE_W-1:0]      i_cfg_data    = '0;

    // A scripted row may carry a typed-in result; it travels with the byte.
    bit      pin_valid  = 1'b0;
    t_result pin_result = '0;

    // Parser model state, at its reset values.
    t_parse_state      pstate       = ST_IDLE;
    logic [3:0]        time_fill    = '0;
    logic [7:0]        staff_fill   = '0;
    logic [7:0]        held_reader  = '0;
    bit                frame_closed = 1'b0;
    logic [BYTE_W-1:0] station_addr = 8'h01;

    t_result pending_results[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      cycles     = 0;
    int      sink_hold  = 0;
    bit      calm_run   = 1'b0;
    bit      calm_tail  = 1'b0;

    typedef struct {
        logic       is_release;
        logic [7:0] rx;
        bit         pinned;
        t_result    want;
    } script_row_t;

    script_row_t script [SCRIPT_LEN];

    rs485_command_frame_receiver_unit #(
        .TIME_BYTES  (TIME_CAP),
        .STAFF_BYTES (STAFF_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs on either handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Parser model
    // -----------------------------------------------------------------------
    function automatic t_event close_frame(t_event ev);
        frame_closed = 1'b1;
        pstate       = ST_DONE;
        return ev;
    endfunction

    // Advances the model by one accepted transaction and returns its result.
    function automatic t_result frame_parse_step(logic is_release, logic [7:0] b);
        t_result r;
        r = RES_EMPTY;
        if (is_release) begin
            pstate       = ST_IDLE;
            frame_closed = 1'b0;
            return r;
        end
        // A finished frame swallows everything until the host releases it.
        if (frame_closed)
            return r;
        // Command bytes restart parsing; unknown ones leave the state alone.
        if ((b & CMD_MASK) == CMD_PATTERN) begin
            case (b)
                CMD_STATUS:  pstate = ST_REQ_ADDR;
                CMD_TIME:    pstate = ST_TIME_BC;
                CMD_STAFF:   pstate = ST_STAFF_BC;
                CMD_FORWARD: pstate = ST_FWD_STATION;
                default: ;
            endcase
            return r;
        end
        case (pstate)
            ST_REQ_ADDR: begin
                pstate = (b == station_addr) ? ST_REQ_END : ST_IDLE;
            end
            ST_REQ_END: begin
                if (b == BYTE_END)
                    r.event_res = close_frame(EV_STATUS);
                else
                    pstate = ST_IDLE;
            end
            ST_TIME_BC: begin
                if (b == BYTE_BCAST) begin
                    pstate    = ST_TIME_DATA;
                    time_fill = '0;
                end
            end
            ST_TIME_DATA: begin
                if (b == BYTE_END || time_fill >= TIME_CAP) begin
                    r.event_res = close_frame(EV_TIME);
                end else begin
                    r.store_valid  = 1'b1;
                    r.store_target = TGT_TIME;
                    r.store_index  = {4'd0, time_fill};
                    r.store_data   = b;
                    time_fill      = time_fill + 4'd1;
                end
            end
            ST_STAFF_BC: begin
                if (b == BYTE_BCAST) begin
                    pstate     = ST_STAFF_DATA;
                    staff_fill = '0;
                end
            end
            ST_STAFF_DATA: begin
                if (b == BYTE_END || staff_fill >= STAFF_CAP) begin
                    r.event_res = close_frame(EV_STAFF);
                end else begin
                    r.store_valid  = 1'b1;
                    r.store_target = TGT_STAFF;
                    r.store_index  = staff_fill;
                    r.store_data   = b;
                    staff_fill     = staff_fill + 8'd1;
                end
            end
            ST_FWD_STATION: begin
                if (b == station_addr)
                    pstate = ST_FWD_READER;
            end
            ST_FWD_READER: begin
                held_reader = b;
                pstate      = ST_FWD_END;
            end
            ST_FWD_END: begin
                if (b == BYTE_END) begin
                    r.reader_number = held_reader;
                    r.event_res     = close_frame(EV_FORWARD);
                end else begin
                    pstate = ST_IDLE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Monitor: predicts on every input transaction, checks every output one.
    // -----------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_result model;
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                station_addr = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                model = frame_parse_step(s_axis_tuser[0], s_axis_tdata);
                pending_results.push_back(pin_valid ? pin_result : model);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.event_res     = t_event'(m_axis_tuser[2:0]);
                got.store_valid   = m_axis_tuser[3];
                got.store_target  = t_target'(m_axis_tuser[4]);
                got.store_index   = m_axis_tdata[7:0];
                got.store_data    = m_axis_tdata[15:8];
                got.reader_number = m_axis_tdata[23:16];
                if (pending_results.size() == 0) begin
                    $error("result transaction arrived with nothing expected");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("event_res", int'(want.event_res), int'(got.event_res));
                    check_field("store_valid", want.store_valid, got.store_valid);
                    check_field("store_target", int'(want.store_target),
                                int'(got.store_target));
                    check_field("store_index", want.store_index, got.store_index);
                    check_field("store_data", want.store_data, got.store_data);
                    check_field("reader_number", want.reader_number, got.reader_number);
                end
            end
        end
    end

    // Result sink: random stalls, none in calm stretches.
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end else if (!calm_run && !calm_tail && $urandom_range(0, 11) == 0) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= $urandom_range(0, 17);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Sender
    // -----------------------------------------------------------------------
    // Holds one transaction until it is taken, then may idle for a burst.
    task automatic push_item(logic is_release, logic [7:0] b, bit pinned, t_result want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= is_release;
        pin_valid     <= pinned;
        pin_result    <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (items_sent >= ITEM_GOAL - CALM_TAIL)
            calm_tail = 1'b1;
        if (!calm_run && !calm_tail && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_rx(logic [7:0] b);
        push_item(1'b0, b, 1'b0, RES_EMPTY);
    endtask

    task automatic send_release();
        push_item(1'b1, 8'($urandom), 1'b0, RES_EMPTY);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_station(logic [7:0] addr);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Payload content: mostly data bytes, now and then a stray command.
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ((b & CMD_MASK) == CMD_PATTERN && $urandom_range(0, 19) != 0)
            b[7] = 1'b0;
        return b;
    endfunction

    function automatic logic [7:0] pick_addr();
        return ($urandom_range(0, 4) != 0) ? station_addr : 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_end();
        return ($urandom_range(0, 6) != 0) ? BYTE_END : 8'($urandom);
    endfunction

    // One random frame, mostly well formed, usually followed by a release.
    task automatic random_frame();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                send_rx(CMD_STATUS);
                send_rx(pick_addr());
                send_rx(pick_end());
            end
            2, 3, 4, 5: begin
                send_rx((kind < 4) ? CMD_TIME : CMD_STAFF);
                if ($urandom_range(0, 4) == 0)
                    send_rx(payload_byte());
                send_rx(BYTE_BCAST);
                if (kind < 4)
                    n = $urandom_range(0, 10);
                else if ($urandom_range(0, 59) == 0)
                    n = $urandom_range(STAFF_CAP - 2, STAFF_CAP + 2);
                else
                    n = $urandom_range(0, 14);
                repeat (n) send_rx(payload_byte());
                send_rx(pick_end());
            end
            6, 7: begin
                send_rx(CMD_FORWARD);
                repeat ($urandom_range(0, 2)) send_rx(payload_byte());
                send_rx(pick_addr());
                send_rx(8'($urandom));
                send_rx(pick_end());
            end
            8: begin
                repeat ($urandom_range(1, 6)) send_rx(8'($urandom));
            end
            default: send_release();
        endcase
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(0, 3)) send_rx(8'($urandom));
            send_release();
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : main_sequence
        logic [7:0] phase_addr [4];
        int         phase_goal;
        script = '{
            // Release straight out of reset, then a status request.
            '{1'b1, 8'hFF,       1'b1, RES_EMPTY},
            '{1'b0, CMD_STATUS,  1'b0, RES_EMPTY},
            '{1'b0, 8'h01,       1'b0, RES_EMPTY},
            '{1'b0, BYTE_END,    1'b1, '{EV_STATUS, 1'b0, TGT_TIME, 8'h00, 8'h00, 8'h00}},
            '{1'b0, 8'h00,       1'b1, RES_EMPTY},
            '{1'b1, 8'h00,       1'b1, RES_EMPTY},
            // Time frame with a stray byte before the broadcast and an unknown command.
            '{1'b0, CMD_TIME,    1'b0, RES_EMPTY},
            '{1'b0, 8'h55,       1'b0, RES_EMPTY},
            '{1'b0, BYTE_BCAST,  1'b0, RES_EMPTY},
            '{1'b0, 8'h00,       1'b1, '{EV_NONE, 1'b1, TGT_TIME, 8'h00, 8'h00, 8'h00}},
            '{1'b0, 8'hFF,       1'b1, '{EV_NONE, 1'b1, TGT_TIME, 8'h01, 8'hFF, 8'h00}},
            '{1'b0, 8'hC0,       1'b0, RES_EMPTY},
            '{1'b0, 8'h3A,       1'b0, RES_EMPTY},
            '{1'b0, BYTE_END,    1'b1, '{EV_TIME, 1'b0, TGT_TIME, 8'h00, 8'h00, 8'h00}},
            '{1'b1, 8'hA5,       1'b0, RES_EMPTY},
            // Forward request behind a station that is not ours.
            '{1'b0, CMD_FORWARD, 1'b0, RES_EMPTY},
            '{1'b0, 8'h02,       1'b0, RES_EMPTY},
            '{1'b0, 8'h01,       1'b0, RES_EMPTY},
            '{1'b0, 8'hAA,       1'b0, RES_EMPTY},
            '{1'b0, BYTE_END,    1'b1, '{EV_FORWARD, 1'b0, TGT_TIME, 8'h00, 8'h00, 8'hAA}},
            '{1'b1, 8'h00,       1'b0, RES_EMPTY},
            // Status request with the wrong station, then a staff frame cut
            // short by a new command inside its payload.
            '{1'b0, CMD_STATUS,  1'b0, RES_EMPTY},
            '{1'b0, 8'h07,       1'b0, RES_EMPTY},
            '{1'b0, CMD_STAFF,   1'b0, RES_EMPTY},
            '{1'b0, BYTE_BCAST,  1'b0, RES_EMPTY},
            '{1'b0, 8'h02,       1'b1, '{EV_NONE, 1'b1, TGT_STAFF, 8'h00, 8'h02, 8'h00}},
            '{1'b0, CMD_STAFF,   1'b0, RES_EMPTY}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            push_item(script[i].is_release, script[i].rx, script[i].pinned, script[i].want);

        // Random frames under both address extremes, a random one, and the
        // reset value again at the end.
        phase_addr[0] = 8'hFF;
        phase_addr[1] = 8'h00;
        phase_addr[2] = 8'($urandom);
        phase_addr[3] = 8'h01;
        for (int p = 0; p < 4; p++) begin
            write_station(phase_addr[p]);
            phase_goal = items_sent + (ITEM_GOAL - items_sent) / (4 - p);
            while (items_sent < phase_goal) begin
                if ($urandom_range(0, 11) == 0)
                    calm_run = !calm_run;
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                random_frame();
            end
        end

        calm_run = 1'b0;
        drain_results();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rcfr_pkg.sv
sv/rcfr_parser.sv
sv/rs485_command_frame_receiver_unit.sv
sv/rcfr_checker.sv
bench/testbench.sv
